FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable and a fixed message.
`define BRT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion with reset disable and a caller message.
`define BRT_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: design/brt_pkg.sv
// Types, constants and angle table functions for the branch ring tessellator.
package brt_pkg;

   localparam int CSR_W = 4;
   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;
   localparam int MIN_SIDES = 3;
   localparam int CORNERS = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS = 16;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   // corner order: start i, start n, end i, end n, end i, start n
   localparam logic [CORNERS-1:0] CORNER_NEXT = 6'b101010;
   localparam logic [CORNERS-1:0] CORNER_END = 6'b011100;

   typedef struct packed {
      logic [47:0] start_center;
      logic [47:0] end_center;
      logic [47:0] start_dir;
      logic [47:0] end_dir;
      logic [15:0] start_radius;
      logic [15:0] end_radius;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic tex_u;
      logic tex_v;
      logic last_vertex;
   } rsp_type;

   typedef struct packed {
      req_type seg;
      logic [CSR_W-1:0] sides;
   } job_type;

   // Sine of r/q of a quarter turn, Q1.14, Taylor series through x^11.
   function automatic logic [15:0] brt_qsin(longint unsigned r, int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x = (r * HALF_PI_Q30) >> (bits - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      sum = (sum + 32768) >>> 16;
      return sum[15:0];
   endfunction

   // {sin, cos} of k/sides of a full turn, Q1.14 each.
   function automatic logic [31:0] brt_sincos(int unsigned k, int unsigned sides,
                                              int unsigned bits);
      longint unsigned q;
      longint unsigned num;
      longint unsigned phase;
      longint unsigned quad;
      longint unsigned r;
      logic [15:0] sr;
      logic [15:0] cr;
      logic [31:0] res;
      if (sides < MIN_SIDES) return '0;
      q = 64'd1 << (bits - 2);
      num = longint'(k) << bits;
      phase = 0;
      while (num >= sides) begin
         num = num - sides;
         phase = phase + 1;
      end
      quad = (phase >> (bits - 2)) & 64'd3;
      r = phase & (q - 1);
      sr = brt_qsin(r, bits);
      cr = brt_qsin(q - r, bits);
      case (quad)
         64'd0: res = {sr, cr};
         64'd1: res = {cr, -sr};
         64'd2: res = {-sr, -cr};
         default: res = {-cr, sr};
      endcase
      return res;
   endfunction

endpackage

FILE: design/brt_front.sv
// Front end: ring_sides register, side count clamp and segment queue.
module brt_front #(
   parameter int MAX_SIDES = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  brt_pkg::req_type req_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [brt_pkg::CSR_W-1:0] csr_data,
   output logic job_valid,
   output brt_pkg::job_type job,
   input  logic job_pop
);
   import brt_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CSR_W-1:0] sides_ff;
   logic [CSR_W-1:0] clamped;
   job_type queue_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic push;
   logic pop;

   assign csr_ready = 1'b1;
   assign req_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign push = req_valid && req_ready;
   assign pop = job_pop && job_valid;
   assign job_valid = (count_ff != '0);
   assign job = queue_ff[rd_ptr_ff];

   always_comb begin
      if (sides_ff < CSR_W'(MIN_SIDES)) begin
         clamped = CSR_W'(MIN_SIDES);
      end else if (sides_ff > CSR_W'(MAX_SIDES)) begin
         clamped = CSR_W'(MAX_SIDES);
      end else begin
         clamped = sides_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sides_ff <= CSR_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            sides_ff <= csr_data;
         end
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{seg: req_payload, sides: clamped};
      end
   end

endmodule

FILE: design/brt_engine.sv
// Back end: ring point computation and vertex emission.
module brt_engine #(
   parameter int MAX_SIDES = 10,
   parameter int ANGLE_TABLE_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  brt_pkg::job_type job,
   output logic job_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output brt_pkg::rsp_type rsp_payload
);
   import brt_pkg::*;

   localparam int KW = $clog2(MAX_SIDES);
   localparam int SW = $clog2(MAX_SIDES + 1);
   localparam int AW = $clog2(2 * MAX_SIDES);
   localparam int DCW = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRIG, ST_PROD, ST_CROSS, ST_SQUARE, ST_SUM,
      ST_SQRT, ST_DIVSET, ST_DIV, ST_ADD, ST_FETCH, ST_EMIT
   } state_type;

   state_type state_ff;
   job_type job_ff;
   logic [KW-1:0] pt_k_ff;
   logic pt_end_ff;
   logic [KW-1:0] side_ff;
   logic [2:0] corner_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_payload_ff;

   logic signed [15:0] sin_tbl [MAX_SIDES+1][MAX_SIDES];
   logic signed [15:0] cos_tbl [MAX_SIDES+1][MAX_SIDES];

   logic signed [15:0] sin_ff, cos_ff, ax_ff, ay_ff, az_ff;
   logic [15:0] rad_ff;
   logic [47:0] ctr_ff;
   logic signed [31:0] p_cay_ff, p_cax_ff, p_saz_ff, p_say_ff;
   logic signed [32:0] cross_ff [3];
   logic [63:0] sq_ff [3];
   logic [47:0] mag_ff [3];
   logic neg_ff [3];
   logic [63:0] rem_ff, root_ff, bit_ff;
   logic [48:0] num_ff [3];
   logic [48:0] dsh_ff;
   logic [15:0] quo_ff [3];
   logic zero_ff;
   logic [47:0] pt_mem [2*MAX_SIDES];
   logic [47:0] emit_ent_ff;

   logic [47:0] dir_sel;
   logic [63:0] trial;
   logic [CSR_W-1:0] sides_m1;
   logic last_pt_k;
   logic last_side;
   logic can_emit;
   logic [KW-1:0] emit_k;
   logic [AW-1:0] emit_addr;
   logic [AW-1:0] wr_addr;
   logic [47:0] pos_pack;

   for (genvar gs = 0; gs <= MAX_SIDES; gs++) begin : g_side
      for (genvar gk = 0; gk < MAX_SIDES; gk++) begin : g_k
         localparam logic [31:0] SC = brt_sincos(gk, gs, ANGLE_TABLE_BITS);
         assign sin_tbl[gs][gk] = SC[31:16];
         assign cos_tbl[gs][gk] = SC[15:0];
      end
   end

   assign job_pop = (state_ff == ST_IDLE) && job_valid;
   assign dir_sel = pt_end_ff ? job_ff.seg.end_dir : job_ff.seg.start_dir;
   assign trial = root_ff + bit_ff;
   assign sides_m1 = job_ff.sides - 1'b1;
   assign last_pt_k = (CSR_W'(pt_k_ff) == sides_m1);
   assign last_side = (CSR_W'(side_ff) == sides_m1);
   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      if (CORNER_NEXT[corner_ff]) begin
         emit_k = last_side ? '0 : side_ff + 1'b1;
      end else begin
         emit_k = side_ff;
      end
      emit_addr = CORNER_END[corner_ff] ? AW'(MAX_SIDES) + AW'(emit_k) : AW'(emit_k);
      wr_addr = pt_end_ff ? AW'(MAX_SIDES) + AW'(pt_k_ff) : AW'(pt_k_ff);
   end

   always_comb begin
      logic signed [16:0] off;
      logic signed [17:0] sum;
      for (int j = 0; j < 3; j++) begin
         off = neg_ff[j] ? -$signed({1'b0, quo_ff[j]}) : $signed({1'b0, quo_ff[j]});
         if (zero_ff) off = '0;
         sum = 18'($signed(ctr_ff[16*j +: 16])) + 18'(off);
         if (sum > 18'sd32767) begin
            pos_pack[16*j +: 16] = 16'h7fff;
         end else if (sum < -18'sd32768) begin
            pos_pack[16*j +: 16] = 16'h8000;
         end else begin
            pos_pack[16*j +: 16] = sum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pt_k_ff <= '0;
         pt_end_ff <= 1'b0;
         side_ff <= '0;
         corner_ff <= '0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && can_emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_payload_ff.pos_x <= emit_ent_ff[15:0];
            rsp_payload_ff.pos_y <= emit_ent_ff[31:16];
            rsp_payload_ff.pos_z <= emit_ent_ff[47:32];
            rsp_payload_ff.tex_u <= CORNER_NEXT[corner_ff];
            rsp_payload_ff.tex_v <= CORNER_END[corner_ff];
            rsp_payload_ff.last_vertex <= last_side && (corner_ff == 3'(CORNERS - 1));
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  pt_k_ff <= '0;
                  pt_end_ff <= 1'b0;
                  state_ff <= ST_TRIG;
               end
            end
            ST_TRIG: state_ff <= ST_PROD;
            ST_PROD: state_ff <= ST_CROSS;
            ST_CROSS: state_ff <= ST_SQUARE;
            ST_SQUARE: state_ff <= ST_SUM;
            ST_SUM: state_ff <= ST_SQRT;
            ST_SQRT: begin
               if (bit_ff[0]) state_ff <= ST_DIVSET;
            end
            ST_DIVSET: begin
               div_cnt_ff <= '0;
               state_ff <= (root_ff == '0) ? ST_ADD : ST_DIV;
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DCW'(DIV_STEPS - 1)) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               if (last_pt_k) begin
                  pt_k_ff <= '0;
                  if (pt_end_ff) begin
                     side_ff <= '0;
                     corner_ff <= '0;
                     state_ff <= ST_FETCH;
                  end else begin
                     pt_end_ff <= 1'b1;
                     state_ff <= ST_TRIG;
                  end
               end else begin
                  pt_k_ff <= pt_k_ff + 1'b1;
                  state_ff <= ST_TRIG;
               end
            end
            ST_FETCH: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (can_emit) begin
                  if (corner_ff == 3'(CORNERS - 1)) begin
                     corner_ff <= '0;
                     if (last_side) begin
                        side_ff <= '0;
                        state_ff <= ST_IDLE;
                     end else begin
                        side_ff <= side_ff + 1'b1;
                        state_ff <= ST_FETCH;
                     end
                  end else begin
                     corner_ff <= corner_ff + 1'b1;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) job_ff <= job;
         end
         ST_TRIG: begin
            sin_ff <= sin_tbl[job_ff.sides[SW-1:0]][pt_k_ff];
            cos_ff <= cos_tbl[job_ff.sides[SW-1:0]][pt_k_ff];
            ax_ff <= dir_sel[15:0];
            ay_ff <= dir_sel[31:16];
            az_ff <= dir_sel[47:32];
            rad_ff <= pt_end_ff ? job_ff.seg.end_radius : job_ff.seg.start_radius;
            ctr_ff <= pt_end_ff ? job_ff.seg.end_center : job_ff.seg.start_center;
         end
         ST_PROD: begin
            p_cay_ff <= cos_ff * ay_ff;
            p_cax_ff <= cos_ff * ax_ff;
            p_saz_ff <= sin_ff * az_ff;
            p_say_ff <= sin_ff * ay_ff;
         end
         ST_CROSS: begin
            cross_ff[0] <= -33'(p_cay_ff);
            cross_ff[1] <= 33'(p_cax_ff) - 33'(p_saz_ff);
            cross_ff[2] <= 33'(p_say_ff);
         end
         ST_SQUARE: begin
            for (int j = 0; j < 3; j++) begin
               logic [32:0] mag_abs;
               mag_abs = cross_ff[j][32] ? 33'(-cross_ff[j]) : 33'(cross_ff[j]);
               sq_ff[j] <= 64'(mag_abs[31:0]) * 64'(mag_abs[31:0]);
               mag_ff[j] <= 48'(mag_abs[31:0]) * 48'(rad_ff);
               neg_ff[j] <= cross_ff[j][32];
            end
         end
         ST_SUM: begin
            rem_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
            root_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         ST_SQRT: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_DIVSET: begin
            zero_ff <= (root_ff == '0);
            for (int j = 0; j < 3; j++) begin
               num_ff[j] <= 49'(mag_ff[j]) + 49'(root_ff[31:1]);
               quo_ff[j] <= '0;
            end
            dsh_ff <= 49'(root_ff[31:0]) << (DIV_STEPS - 1);
         end
         ST_DIV: begin
            for (int j = 0; j < 3; j++) begin
               if (num_ff[j] >= dsh_ff) begin
                  num_ff[j] <= num_ff[j] - dsh_ff;
                  quo_ff[j] <= {quo_ff[j][14:0], 1'b1};
               end else begin
                  quo_ff[j] <= {quo_ff[j][14:0], 1'b0};
               end
            end
            dsh_ff <= dsh_ff >> 1;
         end
         ST_ADD: begin
            pt_mem[wr_addr] <= pos_pack;
         end
         ST_FETCH: begin
            emit_ent_ff <= pt_mem[emit_addr];
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: design/branch_ring_tessellator.sv
// Branch ring tessellator top level.
// One segment item yields 6*S vertex items, S = ring_sides clamped to
// 3..MAX_SIDES. Each of the 2*S ring points takes table lookup, products,
// cross product, squares and their sum, a 32-step square root, a setup
// step, three 16-step dividers side by side and one store; the dividers are
// skipped when the cross product is zero. The 6*S vertices then go out in
// turn, each fetched and then emitted, held while the result side stalls.
// A two-entry queue lets the next segment be accepted while one is in work.
module branch_ring_tessellator #(
   parameter int MAX_SIDES = 10,
   parameter int ANGLE_TABLE_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  brt_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output brt_pkg::rsp_type rsp_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [brt_pkg::CSR_W-1:0] csr_data
);
   import brt_pkg::*;

   logic job_valid;
   logic job_pop;
   job_type job;

   brt_front #(.MAX_SIDES(MAX_SIDES)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .job_valid(job_valid), .job(job), .job_pop(job_pop)
   );

   brt_engine #(.MAX_SIDES(MAX_SIDES), .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_engine (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

endmodule

FILE: design/brt_checker.sv
// Port level checks for the branch ring tessellator, bound to the top level.
`include "assert_macros.svh"

module brt_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input brt_pkg::rsp_type rsp_payload
);

   `BRT_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
   `BRT_ASSERT_MSG(a_last_corner, clock, reset,
      rsp_valid && rsp_payload.last_vertex |-> rsp_payload.tex_u && !rsp_payload.tex_v,
      "last vertex is not the start ring next corner")
   `BRT_ASSERT_MSG(a_corner_order, clock, reset,
      rsp_valid && rsp_ready && rsp_payload.tex_u && rsp_payload.tex_v
         |=> !rsp_valid || (!rsp_payload.tex_u && rsp_payload.tex_v),
      "vertex after end ring next corner out of order")

endmodule

bind branch_ring_tessellator brt_checker u_brt_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
);
